/* rtl/bfba_pkg.sv */
// Shared types, codes and constants of the bitmap free-block allocator.
`timescale 1ns / 1ps

package bfba_pkg;

    // Default sizes
    localparam int MAX_BLOCKS_DEF  = 32768;
    localparam int STACK_DEPTH_DEF = 64;

    // Field and word widths
    localparam int WORD_W    = 64;
    localparam int BIT_W     = 6;
    localparam int IDX_W     = 15;
    localparam int POS_W     = 16;
    localparam int CFG_W     = 16;
    localparam int BATCH_W   = 7;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 32;

    // Request kinds; codes 6 and 7 change nothing and return an ST_OK result
    typedef enum logic [REQ_W-1:0] {
        REQ_CHECK  = 3'd0,
        REQ_SET    = 3'd1,
        REQ_CLEAR  = 3'd2,
        REQ_PUSH   = 3'd3,
        REQ_POP    = 3'd4,
        REQ_REFILL = 3'd5
    } req_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_SKIPPED = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_TOTAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_USED = 3'd4;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_WRAP_Q,
        S_WRAP_R,
        S_MAP_RD,
        S_MAP_MOD,
        S_POP_RD,
        S_RF_RD,
        S_RF_LOAD,
        S_RF_FIND,
        S_RESP
    } state_t;

    // Lowest-set-bit search result
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } lsb_res_t;

endpackage

/* rtl/bfba_lsb_find.sv */
// Lowest set bit search over one bitmap word, as two 8-way priority levels.
`timescale 1ns / 1ps

module bfba_lsb_find
(
    input  logic [bfba_pkg::WORD_W-1:0] vec,
    output bfba_pkg::lsb_res_t          res
);

    localparam int GRP   = 8;
    localparam int GRP_N = bfba_pkg::WORD_W / GRP;

    logic [GRP_N-1:0] grp_any;
    logic [2:0]       grp_sel;
    logic [2:0]       bit_sel;
    logic [GRP-1:0]   grp_bits;

    // Flag each byte that holds a candidate
    always_comb
    begin
        for (int g = 0; g < GRP_N; g++)
        begin
            grp_any[g] = |vec[g*GRP +: GRP];
        end
    end

    // Pick the lowest byte, then the lowest bit inside it
    always_comb
    begin
        grp_sel = 3'd0;
        bit_sel = 3'd0;
        for (int g = GRP_N - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                grp_sel = 3'(g);
            end
        end
        grp_bits = vec[{grp_sel, 3'b000} +: GRP];
        for (int b = GRP - 1; b >= 0; b--)
        begin
            if (grp_bits[b])
            begin
                bit_sel = 3'(b);
            end
        end
    end

    assign res.found = |grp_any;
    assign res.pos   = {grp_sel, bit_sel};

endmodule

/* rtl/bitmap_free_block_allocator.sv */
// Bitmap free-block allocator: validity bitmap, free-index stack and refill scan.
`timescale 1ns / 1ps

// The block handles one request at a time. After reset it runs a clearing pass
// over the bitmap memory, one word per cycle, during which no request word is
// taken; configuration writes are taken at any time. A push or a pop is one
// stack access; for a check, set or clear the index is reduced modulo
// MAX_BLOCKS by a reciprocal multiply in two steps, quotient then remainder,
// then the bitmap word is read and, for a set or clear, written back through
// its one read and one write port. A refill reads the bitmap word by word and
// pushes each free index that it finds onto the stack in turn, since each find
// is one stack write. A finished result waits in the output register, so the
// next request is taken while it waits.

module bitmap_free_block_allocator
#(
    parameter int MAX_BLOCKS  = bfba_pkg::MAX_BLOCKS_DEF,
    parameter int STACK_DEPTH = bfba_pkg::STACK_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Request words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bfba_pkg::S_DATA_W-1:0]     s_tdata,   // [14:0] block_index, [15] zero
    input  logic [bfba_pkg::REQ_W-1:0]        s_tuser,   // [2:0] req_type
    // Result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bfba_pkg::M_DATA_W-1:0]     m_tdata,   // [1:0] status, [2] bit_value,
                                                         // [17:3] popped_index,
                                                         // [24:18] loaded_count, [31:25] zero
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfba_pkg::CFG_W-1:0]        cfg_data
);

    localparam int WORD_W    = bfba_pkg::WORD_W;
    localparam int BIT_W     = bfba_pkg::BIT_W;
    localparam int IDX_W     = bfba_pkg::IDX_W;
    localparam int POS_W     = bfba_pkg::POS_W;
    localparam int BATCH_W   = bfba_pkg::BATCH_W;
    localparam int CW_W      = POS_W - BIT_W;
    localparam int IW        = $clog2(MAX_BLOCKS);
    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int MAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam longint unsigned RECIP = (64'd1 << 32) / MAX_BLOCKS;
    localparam int RW        = $clog2(RECIP + 1);
    localparam int MXW       = $clog2(MAX_BLOCKS + 1);
    localparam int QPW       = IDX_W + RW;
    localparam int RPW       = IDX_W + MXW;
    localparam int SCW       = $clog2(STACK_DEPTH + 1);
    localparam int SAW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Control and configuration state
    bfba_pkg::state_t           state_reg, state_next;
    logic [MAW-1:0]             clr_addr_reg, clr_addr_next;
    logic [POS_W-1:0]           ndb_reg, ndb_next;
    logic [POS_W-1:0]           free_total_reg, free_total_next;
    logic [BATCH_W-1:0]         batch_reg, batch_next;
    logic [POS_W-1:0]           scan_pos_reg, scan_pos_next;
    logic [POS_W-1:0]           used_reg, used_next;
    logic [SCW-1:0]             count_reg, count_next;
    logic                       out_valid_reg, out_valid_next;

    // Working payload
    bfba_pkg::req_t             req_reg, req_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           q_reg, q_next;
    logic [IW-1:0]              widx_reg, widx_next;
    logic [CW_W-1:0]            cur_word_reg, cur_word_next;
    logic [BIT_W-1:0]           lo_off_reg, lo_off_next;
    logic [WORD_W-1:0]          cand_reg, cand_next;
    logic [BATCH_W-1:0]         limit_reg, limit_next;
    logic [BATCH_W-1:0]         loaded_reg, loaded_next;
    bfba_pkg::status_t          status_reg, status_next;
    logic                       bit_reg, bit_next;
    logic [IDX_W-1:0]           popped_reg, popped_next;
    logic [bfba_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    // Memories and their ports
    logic [WORD_W-1:0]          map_mem [MAP_WORDS];
    logic [WORD_W-1:0]          map_rdata_reg;
    logic                       map_rd_en;
    logic [MAW-1:0]             map_rd_addr;
    logic                       map_wr_en;
    logic [MAW-1:0]             map_wr_addr;
    logic [WORD_W-1:0]          map_wr_data;

    logic [IDX_W-1:0]           stk_mem [STACK_DEPTH];
    logic [IDX_W-1:0]           stk_rdata_reg;
    logic                       stk_rd_en;
    logic [SAW-1:0]             stk_rd_addr;
    logic                       stk_wr_en;
    logic [SAW-1:0]             stk_wr_addr;
    logic [IDX_W-1:0]           stk_wr_data;

    // Shared decode
    logic [POS_W-1:0]           end_pos;
    logic                       rf_skip;
    logic                       rf_at_end;
    logic [POS_W:0]             word_base;
    logic [POS_W:0]             next_base;
    logic [POS_W:0]             rem_bits;
    logic [WORD_W-1:0]          lo_mask;
    logic [WORD_W-1:0]          hi_mask;
    logic [POS_W-1:0]           find_idx;
    logic [POS_W-1:0]           used_inc;
    logic [BATCH_W-1:0]         loaded_inc;
    logic                       rf_stop;
    logic [BATCH_W-1:0]         lim_raw;
    logic [QPW-1:0]             q_prod;
    logic [RPW-1:0]             qm_prod;
    logic [RPW-1:0]             rem_raw;
    logic [RPW-1:0]             rem_fix;
    logic [WORD_W-1:0]          bit_mask;
    logic                       out_free;
    bfba_pkg::lsb_res_t         lsb_res;

    // Lowest free bit among the scan candidates
    bfba_lsb_find u_lsb_find
    (
        .vec (cand_reg),
        .res (lsb_res)
    );

    assign s_tready  = (state_reg == bfba_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // Scan limits and refill stop conditions
    assign end_pos    = (int'(ndb_reg) > MAX_BLOCKS) ? POS_W'(MAX_BLOCKS) : ndb_reg;
    assign rf_skip    = (count_reg != '0) || (used_reg >= free_total_reg);
    assign rf_at_end  = (scan_pos_reg >= end_pos);
    assign word_base  = {1'b0, cur_word_reg, {BIT_W{1'b0}}};
    assign next_base  = word_base + (POS_W+1)'(WORD_W);
    assign rem_bits   = {1'b0, end_pos} - word_base;
    assign lo_mask    = {WORD_W{1'b1}} << lo_off_reg;
    assign hi_mask    = (rem_bits >= (POS_W+1)'(WORD_W)) ? {WORD_W{1'b1}}
                      : ((WORD_W'(1) << rem_bits[BIT_W-1:0]) - WORD_W'(1));
    assign find_idx   = {cur_word_reg, lsb_res.pos};
    assign used_inc   = used_reg + POS_W'(1);
    assign loaded_inc = loaded_reg + BATCH_W'(1);
    assign rf_stop    = (used_inc >= free_total_reg) || (loaded_inc >= limit_reg);
    assign lim_raw    = (batch_reg == '0) ? BATCH_W'(1) : batch_reg;

    // Index reduction: quotient estimate, then remainder with one correction
    assign q_prod   = QPW'(idx_reg) * QPW'(RECIP);
    assign qm_prod  = RPW'(q_reg) * RPW'(MAX_BLOCKS);
    assign rem_raw  = RPW'(idx_reg) - qm_prod;
    assign rem_fix  = (rem_raw >= RPW'(MAX_BLOCKS)) ? rem_raw - RPW'(MAX_BLOCKS) : rem_raw;
    assign bit_mask = WORD_W'(1) << widx_reg[BIT_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfba_pkg::S_CLEAR:
            begin
                if (clr_addr_reg == MAW'(MAP_WORDS - 1))
                begin
                    state_next = bfba_pkg::S_IDLE;
                end
            end
            bfba_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = bfba_pkg::S_DISPATCH;
                end
            end
            bfba_pkg::S_DISPATCH:
            begin
                unique case (req_reg)
                    bfba_pkg::REQ_CHECK,
                    bfba_pkg::REQ_SET,
                    bfba_pkg::REQ_CLEAR:  state_next = bfba_pkg::S_WRAP_Q;
                    bfba_pkg::REQ_POP:
                        state_next = (count_reg == '0) ? bfba_pkg::S_RESP : bfba_pkg::S_POP_RD;
                    bfba_pkg::REQ_REFILL:
                        state_next = (rf_skip || rf_at_end) ? bfba_pkg::S_RESP
                                                            : bfba_pkg::S_RF_RD;
                    default:              state_next = bfba_pkg::S_RESP;
                endcase
            end
            bfba_pkg::S_WRAP_Q:  state_next = bfba_pkg::S_WRAP_R;
            bfba_pkg::S_WRAP_R:  state_next = bfba_pkg::S_MAP_RD;
            bfba_pkg::S_MAP_RD:  state_next = bfba_pkg::S_MAP_MOD;
            bfba_pkg::S_MAP_MOD: state_next = bfba_pkg::S_RESP;
            bfba_pkg::S_POP_RD:  state_next = bfba_pkg::S_RESP;
            bfba_pkg::S_RF_RD:   state_next = bfba_pkg::S_RF_LOAD;
            bfba_pkg::S_RF_LOAD: state_next = bfba_pkg::S_RF_FIND;
            bfba_pkg::S_RF_FIND:
            begin
                if (lsb_res.found)
                begin
                    if (rf_stop)
                    begin
                        state_next = bfba_pkg::S_RESP;
                    end
                end
                else if (next_base >= {1'b0, end_pos})
                begin
                    state_next = bfba_pkg::S_RESP;
                end
                else
                begin
                    state_next = bfba_pkg::S_RF_RD;
                end
            end
            bfba_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = bfba_pkg::S_IDLE;
                end
            end
            default: state_next = bfba_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        ndb_next        = ndb_reg;
        free_total_next = free_total_reg;
        batch_next      = batch_reg;
        scan_pos_next   = scan_pos_reg;
        used_next       = used_reg;
        count_next      = count_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        q_next          = q_reg;
        widx_next       = widx_reg;
        cur_word_next   = cur_word_reg;
        lo_off_next     = lo_off_reg;
        cand_next       = cand_reg;
        limit_next      = limit_reg;
        loaded_next     = loaded_reg;
        status_next     = status_reg;
        bit_next        = bit_reg;
        popped_next     = popped_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        map_rd_en   = 1'b0;
        map_rd_addr = MAW'(widx_reg >> BIT_W);
        map_wr_en   = 1'b0;
        map_wr_addr = MAW'(widx_reg >> BIT_W);
        map_wr_data = map_rdata_reg;
        stk_rd_en   = 1'b0;
        stk_rd_addr = SAW'(count_reg - SCW'(1));
        stk_wr_en   = 1'b0;
        stk_wr_addr = SAW'(count_reg);
        stk_wr_data = idx_reg;

        // Take configuration writes
        if (cfg_valid)
        begin
            priority case (cfg_index)
                bfba_pkg::CFG_NUM_BLOCKS: ndb_next        = cfg_data;
                bfba_pkg::CFG_FREE_TOTAL: free_total_next = cfg_data;
                bfba_pkg::CFG_BATCH:      batch_next      = cfg_data[BATCH_W-1:0];
                bfba_pkg::CFG_START_POS:  scan_pos_next   = cfg_data;
                bfba_pkg::CFG_START_USED: used_next       = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            bfba_pkg::S_CLEAR:
            begin
                map_wr_en     = 1'b1;
                map_wr_addr   = clr_addr_reg;
                map_wr_data   = '0;
                clr_addr_next = clr_addr_reg + MAW'(1);
            end
            bfba_pkg::S_IDLE:
            begin
                // Latch the request and clear the result fields
                req_next    = bfba_pkg::req_t'(s_tuser);
                idx_next    = s_tdata[IDX_W-1:0];
                status_next = bfba_pkg::ST_OK;
                bit_next    = 1'b0;
                popped_next = '0;
                loaded_next = '0;
            end
            bfba_pkg::S_DISPATCH:
            begin
                unique case (req_reg)
                    bfba_pkg::REQ_PUSH:
                    begin
                        if (count_reg >= SCW'(STACK_DEPTH))
                        begin
                            status_next = bfba_pkg::ST_FULL;
                        end
                        else
                        begin
                            stk_wr_en  = 1'b1;
                            count_next = count_reg + SCW'(1);
                        end
                    end
                    bfba_pkg::REQ_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = bfba_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            stk_rd_en  = 1'b1;
                            count_next = count_reg - SCW'(1);
                        end
                    end
                    bfba_pkg::REQ_REFILL:
                    begin
                        if (rf_skip)
                        begin
                            status_next = bfba_pkg::ST_SKIPPED;
                        end
                        cur_word_next = scan_pos_reg[POS_W-1:BIT_W];
                        lo_off_next   = scan_pos_reg[BIT_W-1:0];
                        limit_next    = (int'(lim_raw) > STACK_DEPTH) ? BATCH_W'(STACK_DEPTH)
                                                                      : lim_raw;
                    end
                    default: ;
                endcase
            end
            bfba_pkg::S_WRAP_Q:
            begin
                q_next = IDX_W'(q_prod >> 32);
            end
            bfba_pkg::S_WRAP_R:
            begin
                widx_next = IW'(rem_fix);
            end
            bfba_pkg::S_MAP_RD:
            begin
                map_rd_en = 1'b1;
            end
            bfba_pkg::S_MAP_MOD:
            begin
                // Read, or write back the word with one bit changed
                unique case (req_reg)
                    bfba_pkg::REQ_SET:
                    begin
                        map_wr_en   = 1'b1;
                        map_wr_data = map_rdata_reg | bit_mask;
                    end
                    bfba_pkg::REQ_CLEAR:
                    begin
                        map_wr_en   = 1'b1;
                        map_wr_data = map_rdata_reg & ~bit_mask;
                    end
                    default:
                    begin
                        bit_next = map_rdata_reg[widx_reg[BIT_W-1:0]];
                    end
                endcase
            end
            bfba_pkg::S_POP_RD:
            begin
                popped_next = stk_rdata_reg;
            end
            bfba_pkg::S_RF_RD:
            begin
                map_rd_en   = 1'b1;
                map_rd_addr = MAW'(cur_word_reg);
            end
            bfba_pkg::S_RF_LOAD:
            begin
                cand_next = ~map_rdata_reg & lo_mask & hi_mask;
            end
            bfba_pkg::S_RF_FIND:
            begin
                if (lsb_res.found)
                begin
                    // Push the find and advance position and counts
                    stk_wr_en     = 1'b1;
                    stk_wr_data   = find_idx[IDX_W-1:0];
                    count_next    = count_reg + SCW'(1);
                    scan_pos_next = find_idx + POS_W'(1);
                    used_next     = used_inc;
                    loaded_next   = loaded_inc;
                    cand_next     = cand_reg & ~(WORD_W'(1) << lsb_res.pos);
                end
                else
                begin
                    cur_word_next = cur_word_reg + CW_W'(1);
                    lo_off_next   = '0;
                end
            end
            bfba_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, loaded_reg, popped_reg, bit_reg, status_reg};
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bfba_pkg::S_CLEAR;
            clr_addr_reg   <= '0;
            ndb_reg        <= 16'h8000;
            free_total_reg <= '0;
            batch_reg      <= 7'd64;
            scan_pos_reg   <= '0;
            used_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            ndb_reg        <= ndb_next;
            free_total_reg <= free_total_next;
            batch_reg      <= batch_next;
            scan_pos_reg   <= scan_pos_next;
            used_reg       <= used_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        q_reg        <= q_next;
        widx_reg     <= widx_next;
        cur_word_reg <= cur_word_next;
        lo_off_reg   <= lo_off_next;
        cand_reg     <= cand_next;
        limit_reg    <= limit_next;
        loaded_reg   <= loaded_next;
        status_reg   <= status_next;
        bit_reg      <= bit_next;
        popped_reg   <= popped_next;
        out_data_reg <= out_data_next;
    end

    // Bitmap memory
    always_ff @(posedge clk)
    begin
        if (map_wr_en)
        begin
            map_mem[map_wr_addr] <= map_wr_data;
        end
        if (map_rd_en)
        begin
            map_rdata_reg <= map_mem[map_rd_addr];
        end
    end

    // Free-index stack memory
    always_ff @(posedge clk)
    begin
        if (stk_wr_en)
        begin
            stk_mem[stk_wr_addr] <= stk_wr_data;
        end
        if (stk_rd_en)
        begin
            stk_rdata_reg <= stk_mem[stk_rd_addr];
        end
    end

    // Stack fill never passes its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SCW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // A refill find stays within the batch limit and the stack
    a_find_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfba_pkg::S_RF_FIND && lsb_res.found)
        |-> (loaded_reg < limit_reg && count_reg < SCW'(STACK_DEPTH)))
        else $error("refill find beyond batch limit or stack depth");

    // A successful pop lowers the count by exactly one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfba_pkg::S_POP_RD) |-> (count_reg + SCW'(1)) == $past(count_reg))
        else $error("pop did not lower stack count by one");

    // A finished request shows its result and frees the input side
    a_resp_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfba_pkg::S_RESP && out_free)
        |=> (out_valid_reg && state_reg == bfba_pkg::S_IDLE))
        else $error("result not presented after completion");

endmodule
